@@ sv/sha_pkg.sv @@
// package: types, constants and round functions shared by the hasher modules
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  // block handed from the front part to the back part
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_ROUND,
    BE_UPDATE,
    BE_EMIT
  } be_state_e;

  typedef enum logic [1:0] {
    FE_TAKE,
    FE_PAD,
    FE_ZERO,
    FE_LEN
  } fe_state_e;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

@@ sv/sha256_stream_hasher.sv @@
// bytes fill a 64-byte block at one word per cycle while the front part is ready;
// each block then runs in the round engine (one round per cycle plus load and update),
// which takes a new block only once it is done with the last; the block queue lets the
// next block fill while rounds run; digest words leave one a cycle while tready is high
// reset: asynchronous active low, hash state returns to the initial values
`timescale 1ns / 1ps
module sha256_stream_hasher #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
  input  logic        s_axis_tuser,  // has_byte
  input  logic        s_axis_tlast,  // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_axis_tlast   // last_word
);
  import sha_pkg::*;

  blk_t        f_blk, q_blk;
  logic        f_valid, f_ready, q_valid, q_ready;
  logic [31:0] word;
  logic [2:0]  idx;

  sha_front u_front (
    .clk_i, .rst_ni,
    .byte_i(s_axis_tdata),
    .has_byte_i(s_axis_tuser),
    .eom_i(s_axis_tlast),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .blk_o(f_blk),
    .blk_valid_o(f_valid),
    .blk_ready_i(f_ready)
  );

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_data_i(f_blk), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_data_o(q_blk), .rd_valid_o(q_valid), .rd_ready_i(q_ready)
  );

  sha_back u_back (
    .clk_i, .rst_ni,
    .blk_i(q_blk), .blk_valid_i(q_valid), .blk_ready_o(q_ready),
    .word_o(word), .idx_o(idx), .last_o(m_axis_tlast),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, idx, word};

endmodule

@@ sv/sha_front.sv @@
// front part: gathers bytes into blocks and adds the padding and length
`timescale 1ns / 1ps
module sha_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       byte_i,
  input  logic             has_byte_i,
  input  logic             eom_i,
  input  logic             valid_i,
  output logic             ready_o,
  output sha_pkg::blk_t    blk_o,
  output logic             blk_valid_o,
  input  logic             blk_ready_i
);
  import sha_pkg::*;

  fe_state_e    state_q, state_d;
  logic [511:0] blk_q;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  total_q, total_d;
  logic [63:0]  bits_q, bits_d;
  logic [2:0]   len_idx_q, len_idx_d;
  logic         wr_en;
  logic [7:0]   wr_byte;
  logic         blk_pend_q, blk_pend_d;
  logic         blk_final_q, blk_final_d;
  logic         stall;

  // a full block waits here until the queue takes it
  assign stall = blk_pend_q && !blk_ready_i;
  assign blk_valid_o = blk_pend_q;

  assign blk_o.block = blk_q;
  assign blk_o.final_blk = blk_final_q;

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    total_d = total_q;
    bits_d = bits_q;
    len_idx_d = len_idx_q;
    blk_pend_d = blk_pend_q && !blk_ready_i;
    blk_final_d = blk_final_q;
    wr_en = 1'b0;
    wr_byte = byte_i;
    ready_o = 1'b0;
    if (!stall) begin
      case (state_q)
        FE_TAKE: begin
          ready_o = 1'b1;
          if (valid_i) begin
            if (has_byte_i) begin
              wr_en = 1'b1;
              total_d = total_q + 64'd1;
            end
            if (eom_i) begin
              state_d = FE_PAD;
              bits_d = (has_byte_i ? total_q + 64'd1 : total_q) << 3;
            end
          end
        end
        FE_PAD: begin
          wr_en = 1'b1;
          wr_byte = PadMark;
        end
        FE_ZERO: begin
          if (fill_q == LenPos) begin
            state_d = FE_LEN;
            len_idx_d = 3'd0;
          end else begin
            wr_en = 1'b1;
            wr_byte = 8'h00;
          end
        end
        FE_LEN: begin
          wr_en = 1'b1;
          wr_byte = bits_q[63 - 8*len_idx_q -: 8];
          len_idx_d = len_idx_q + 3'd1;
        end
        default: state_d = FE_TAKE;
      endcase
      if (wr_en) begin
        fill_d = fill_q + 6'd1;
        if (state_q == FE_PAD) begin
          state_d = FE_ZERO;
        end
        if (fill_q == 6'd63) begin
          blk_pend_d = 1'b1;
          blk_final_d = (state_q == FE_LEN);
        end
        if (state_q == FE_LEN && len_idx_q == 3'd7) begin
          state_d = FE_TAKE;
          total_d = '0;
        end
      end
    end
  end

  // bytes shift in at the low end, so the first byte ends up at the top
  always_ff @(posedge clk_i) begin
    if (wr_en && !stall) begin
      blk_q <= {blk_q[503:0], wr_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_TAKE;
      fill_q <= '0;
      total_q <= '0;
      bits_q <= '0;
      len_idx_q <= '0;
      blk_pend_q <= 1'b0;
      blk_final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      total_q <= total_d;
      bits_q <= bits_d;
      len_idx_q <= len_idx_d;
      blk_pend_q <= blk_pend_d;
      blk_final_q <= blk_final_d;
    end
  end

endmodule

@@ sv/sha_queue.sv @@
// short block queue between the front and back parts
`timescale 1ns / 1ps
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sha_pkg::blk_t wr_data_i,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  output sha_pkg::blk_t rd_data_o,
  output logic          rd_valid_o,
  input  logic          rd_ready_i
);
  import sha_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  blk_t           mem_q [Depth];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;
  logic           push, pop;

  assign wr_ready_o = (cnt_q != Depth[AW:0]);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      end
      if (pop) begin
        rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
      end
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

@@ sv/sha_back.sv @@
// back part: 64-round compression engine and digest word output
`timescale 1ns / 1ps
module sha_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sha_pkg::blk_t blk_i,
  input  logic          blk_valid_i,
  output logic          blk_ready_o,
  output logic [31:0]   word_o,
  output logic [2:0]    idx_o,
  output logic          last_o,
  output logic          valid_o,
  input  logic          ready_i
);
  import sha_pkg::*;

  be_state_e   state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q, rnd_d;
  logic        fin_q, fin_d;
  logic [2:0]  oi_q, oi_d;
  logic        load, step, upd, reset_h;
  logic [31:0] wr, s0, s1, t1, t2, big0, big1, chs, maj;

  assign wr = w_q[0];
  assign s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
  assign chs = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1 = v_q[7] + big1 + chs + round_k(rnd_q) + wr;
  assign big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2 = big0 + maj;

  assign word_o = h_q[oi_q];
  assign idx_o = oi_q;
  assign last_o = (oi_q == 3'd7);

  always_comb begin
    state_d = state_q;
    rnd_d = rnd_q;
    fin_d = fin_q;
    oi_d = oi_q;
    load = 1'b0;
    step = 1'b0;
    upd = 1'b0;
    reset_h = 1'b0;
    blk_ready_o = 1'b0;
    valid_o = 1'b0;
    case (state_q)
      BE_IDLE: begin
        blk_ready_o = 1'b1;
        if (blk_valid_i) begin
          load = 1'b1;
          fin_d = blk_i.final_blk;
          rnd_d = '0;
          state_d = BE_ROUND;
        end
      end
      BE_ROUND: begin
        step = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = BE_UPDATE;
        end
      end
      BE_UPDATE: begin
        upd = 1'b1;
        oi_d = '0;
        state_d = fin_q ? BE_EMIT : BE_IDLE;
      end
      BE_EMIT: begin
        valid_o = 1'b1;
        if (ready_i) begin
          oi_d = oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            reset_h = 1'b1;
            state_d = BE_IDLE;
          end
        end
      end
      default: state_d = BE_IDLE;
    endcase
  end

  // rolling schedule: slot 0 is the word of the current round
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int j = 0; j < 16; j++) begin
        w_q[j] <= blk_i.block[511 - 32*j -: 32];
      end
      for (int j = 0; j < 8; j++) begin
        v_q[j] <= h_q[j];
      end
    end else if (step) begin
      for (int j = 0; j < 15; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[15] <= w_q[0] + s0 + w_q[9] + s1;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      rnd_q <= '0;
      fin_q <= 1'b0;
      oi_q <= '0;
      for (int j = 0; j < 8; j++) begin
        h_q[j] <= init_hash(3'(j));
      end
    end else begin
      state_q <= state_d;
      rnd_q <= rnd_d;
      fin_q <= fin_d;
      oi_q <= oi_d;
      if (upd) begin
        for (int j = 0; j < 8; j++) begin
          h_q[j] <= h_q[j] + v_q[j];
        end
      end else if (reset_h) begin
        for (int j = 0; j < 8; j++) begin
          h_q[j] <= init_hash(3'(j));
        end
      end
    end
  end

endmodule

@@ sv/sha_checker.sv @@
// checker: port-level properties of the hasher, bound to the top level
`timescale 1ns / 1ps
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast does not match word index");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:35] == 5'd0))
    else $error("output fill bits not zero");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("digest words not consecutive");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled word changed");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

@@ sim/tb.sv @@
// testbench: sha256 stream hasher checked word by word against a behavioural digest predictor
`timescale 1ns / 1ps
module tb;
  import sha_pkg::*;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  class digest_board;
    digest_out_t pending[$];
    int errors;
    int words_seen;
    logic [31:0] h[8];
    logic [7:0]  blk[64];
    int unsigned fill;
    logic [63:0] total;

    function void restart();
      for (int i = 0; i < 8; i++) h[i] = init_hash(i[2:0]);
      fill = 0;
      total = 64'd0;
    endfunction

    function logic [31:0] rr(logic [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
    endfunction

    function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int j = 0; j < 16; j++)
        w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
      for (int j = 16; j < 64; j++) begin
        s0 = rr(w[j-15], 7) ^ rr(w[j-15], 18) ^ (w[j-15] >> 3);
        s1 = rr(w[j-2], 17) ^ rr(w[j-2], 19) ^ (w[j-2] >> 10);
        w[j] = w[j-16] + s0 + w[j-7] + s1;
      end
      for (int j = 0; j < 8; j++) v[j] = h[j];
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(r[5:0]) + w[r];
        t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) h[j] += v[j];
    endfunction

    function void add_byte(logic [7:0] b);
      blk[fill] = b;
      fill = (fill + 1) % 64;
      if (fill == 0) compress();
    endfunction

    function void note_input(logic [7:0] b, logic has, logic fin);
      logic [63:0] bits;
      digest_out_t d;
      if (has) begin
        total += 64'd1;
        add_byte(b);
      end
      if (!fin) return;
      bits = total << 3;
      add_byte(PadMark);
      while (fill != LenPos) add_byte(8'h00);
      for (int i = 0; i < 8; i++) add_byte(bits[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = h[i];
        d.word_index = i[2:0];
        d.last_word = (i == 7);
        pending.push_back(d);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] dw, logic [2:0] wi, logic lw);
      digest_out_t e;
      words_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest word %h idx %0d last %0b", $time, dw, wi, lw);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (dw !== e.digest_word) begin
        $display("%0t: digest_word exp %h got %h", $time, e.digest_word, dw);
        errors++;
      end
      if (wi !== e.word_index) begin
        $display("%0t: word_index exp %0d got %0d", $time, e.word_index, wi);
        errors++;
      end
      if (lw !== e.last_word) begin
        $display("%0t: last_word exp %0b got %0b", $time, e.last_word, lw);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;

  digest_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_off = 0;
  int messages = 0;
  int words_sent = 0;

  always #1 clk_i = ~clk_i;

  sha256_stream_hasher uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // receiver: random stalls plus optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_off <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(logic [7:0] b, logic has, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= has;
    s_axis_tlast <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_input(b, has, fin);
    words_sent++;
    if (fin) messages++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++)
      send_word(8'($urandom_range(255)), 1'b1, (i == len - 1));
    if (len == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int r, len;
    int target;
    target = words_sent + n;
    while (words_sent < target) begin
      r = int'($urandom_range(99));
      if (r < 70) begin
        r = int'($urandom_range(99));
        len = (r < 80) ? int'($urandom_range(20)) : int'($urandom_range(54, 70));
        send_message(len);
      end else if (r < 85) begin
        send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      end else begin
        send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    #20000000;
    $display("sha256_stream_hasher regression: fail");
    $finish;
  end

  initial begin
    board.errors = 0;
    board.words_seen = 0;
    board.restart();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty, ignored item, extremes, block edges
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_message(3);
    send_message(5);
    drain();
    send_message(55);
    send_message(56);
    send_message(64);
    drain();

    random_phase(40);
    drain();
    send_idle_pct = 46;
    random_phase(40);
    send_idle_pct = 0;
    recv_stall_pct = 46;
    random_phase(40);
    // long receiver hold-off while input keeps coming
    recv_stall_pct = 0;
    hold_reqs = hold_reqs + 1;
    for (int i = 0; i < 10; i++) send_message(1);
    drain();
    send_idle_pct = 32;
    recv_stall_pct = 32;
    random_phase(40);
    drain();
    repeat (200) @(posedge clk_i);

    $display("%0d input words, %0d messages, %0d digest words checked",
             words_sent, messages, board.words_seen);
    $display("covered empty and block-edge messages, idle and stall mixes, a full queue");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("sha256_stream_hasher regression: pass");
    else
      $display("sha256_stream_hasher regression: fail");
    $finish;
  end
endmodule
